// ===== src/sitp_pkg.sv =====
package sitp_pkg;

  localparam int unsigned AddrW     = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NumBytes  = 8;
  localparam int unsigned SigW      = 10;
  localparam int unsigned AccW      = 11;
  localparam int unsigned FoldShift = 8;
  localparam int unsigned RotPeriod = 4;
  localparam logic [SigW-1:0] SigMask = 10'h3FF;

  // reciprocal for the slot modulo: q = (sig * M) >> RecipShift, off by at most one low
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = 21;

  typedef enum logic [1:0] {
    OUT_STORED = 2'd0,
    OUT_PAIRED = 2'd1,
    OUT_HELD   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_DECIDE
  } back_state_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [SigW-1:0]  sig;
    logic [SigW-1:0]  idx;
  } sitp_job_t;

  function automatic logic [SigW-1:0] hash_sig(input logic [NumBytes-1:0][ByteW-1:0] b);
    logic [AccW-1:0] acc;
    acc = '0;
    for (int i = 0; i < NumBytes; i++) begin
      acc = acc ^ (AccW'(b[i]) << (i % RotPeriod));
    end
    acc = acc ^ (acc >> FoldShift);
    return acc[SigW-1:0] & SigMask;
  endfunction

endpackage

// ===== src/sitp_if.sv =====
interface sitp_in_if import sitp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] line_address;
  logic [ByteW-1:0] sample_byte_0;
  logic [ByteW-1:0] sample_byte_1;
  logic [ByteW-1:0] sample_byte_2;
  logic [ByteW-1:0] sample_byte_3;
  logic [ByteW-1:0] sample_byte_4;
  logic [ByteW-1:0] sample_byte_5;
  logic [ByteW-1:0] sample_byte_6;
  logic [ByteW-1:0] sample_byte_7;

  modport source (
    output valid, line_address, sample_byte_0, sample_byte_1, sample_byte_2,
           sample_byte_3, sample_byte_4, sample_byte_5, sample_byte_6, sample_byte_7,
    input  ready
  );
  modport sink (
    input  valid, line_address, sample_byte_0, sample_byte_1, sample_byte_2,
           sample_byte_3, sample_byte_4, sample_byte_5, sample_byte_6, sample_byte_7,
    output ready
  );
  modport monitor (
    input valid, ready, line_address, sample_byte_0, sample_byte_1, sample_byte_2,
          sample_byte_3, sample_byte_4, sample_byte_5, sample_byte_6, sample_byte_7
  );
endinterface

interface sitp_out_if import sitp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic [SigW-1:0]  signature;
  logic [SigW-1:0]  slot_index;
  logic [AddrW-1:0] partner_address;

  modport source (
    output valid, outcome, signature, slot_index, partner_address,
    input  ready
  );
  modport sink (
    input  valid, outcome, signature, slot_index, partner_address,
    output ready
  );
  modport monitor (
    input valid, ready, outcome, signature, slot_index, partner_address
  );
endinterface

// ===== src/sitp_front.sv =====
module sitp_front import sitp_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sitp_in_if.sink    in_i,
  input  logic       busy_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output sitp_job_t  push_job_o
);

  localparam int unsigned IdxW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SlotW = SigW + 1;
  localparam int unsigned ProdW = SigW + RecipW;
  localparam logic [RecipW-1:0] RecipM = RecipW'((1 << RecipShift) / TABLE_SLOTS);
  localparam logic [SlotW-1:0]  Slots  = SlotW'(TABLE_SLOTS);

  logic                      a_valid_q;
  logic [AddrW-1:0]          a_addr_q;
  logic [SigW-1:0]           a_sig_q;
  logic [ProdW-1:0]          a_prod_q;
  logic [SigW-1:0]           sig_d;
  logic [ProdW-1:0]          prod_d;
  logic [SigW-1:0]           quot;
  logic [SigW+SlotW-1:0]     quot_slots;
  logic [SlotW-1:0]          rem;
  logic [SlotW-1:0]          rem_fix;
  logic                      accept;
  logic                      advance;

  assign advance     = a_valid_q && push_ready_i;
  assign in_i.ready  = !busy_i && (!a_valid_q || push_ready_i);
  assign accept      = in_i.valid && in_i.ready;

  assign sig_d  = hash_sig({in_i.sample_byte_7, in_i.sample_byte_6, in_i.sample_byte_5,
                            in_i.sample_byte_4, in_i.sample_byte_3, in_i.sample_byte_2,
                            in_i.sample_byte_1, in_i.sample_byte_0});
  assign prod_d = ProdW'(sig_d) * ProdW'(RecipM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (advance) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_addr_q <= in_i.line_address;
      a_sig_q  <= sig_d;
      a_prod_q <= prod_d;
    end
  end

  // slot index: reciprocal estimate then one correction step
  assign quot       = a_prod_q[RecipShift +: SigW];
  assign quot_slots = (SigW+SlotW)'(quot) * (SigW+SlotW)'(Slots);
  assign rem        = SlotW'((SigW+SlotW)'(a_sig_q) - quot_slots);
  assign rem_fix    = (rem >= Slots) ? (rem - Slots) : rem;

  assign push_valid_o    = a_valid_q;
  assign push_job_o.addr = a_addr_q;
  assign push_job_o.sig  = a_sig_q;
  assign push_job_o.idx  = SigW'(rem_fix[IdxW-1:0]);

endmodule

// ===== src/sitp_queue.sv =====
module sitp_queue import sitp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  sitp_job_t  push_job_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output sitp_job_t  pop_job_o
);

  sitp_job_t  slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== src/sitp_back.sv =====
module sitp_back import sitp_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  sitp_job_t  pop_job_i,
  output logic       busy_o,
  sitp_out_if.source out_o
);

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned EntW = AddrW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_SLOTS - 1);

  back_state_e      state_q, state_d;
  logic [IdxW-1:0]  clr_cnt_q;
  logic [EntW-1:0]  mem_q [TABLE_SLOTS];
  logic [EntW-1:0]  rdata_q;
  sitp_job_t        cur_q;

  logic             out_valid_q;
  outcome_e         out_outcome_q, outcome_d;
  logic [SigW-1:0]  out_sig_q;
  logic [SigW-1:0]  out_idx_q;
  logic [AddrW-1:0] out_partner_q, partner_d;

  logic             out_free;
  logic             take;
  logic             finish;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [EntW-1:0]  wr_data;
  logic             slot_valid;
  logic [AddrW-1:0] slot_addr;

  assign out_free   = !out_valid_q || out_o.ready;
  assign slot_valid = rdata_q[AddrW];
  assign slot_addr  = rdata_q[AddrW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR:  if (clr_cnt_q == LastIdx) state_d = BK_IDLE;
      BK_IDLE:   if (pop_valid_i) state_d = BK_READ;
      BK_READ:   state_d = BK_DECIDE;
      BK_DECIDE: if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    finish    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_q.idx[IdxW-1:0];
    wr_data   = '0;
    outcome_d = OUT_HELD;
    partner_d = '0;
    busy_o    = 1'b0;
    priority if (!slot_valid) begin
      outcome_d = OUT_STORED;
    end else if (slot_addr != cur_q.addr) begin
      outcome_d = OUT_PAIRED;
      partner_d = slot_addr;
    end else begin
      outcome_d = OUT_HELD;
    end
    unique case (state_q)
      BK_CLEAR: begin
        busy_o  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
      end
      BK_IDLE:  take = pop_valid_i;
      BK_READ:  ;
      BK_DECIDE: begin
        finish = out_free;
        if (outcome_d == OUT_STORED) begin
          wr_en   = out_free;
          wr_data = {1'b1, cur_q.addr};
        end else if (outcome_d == OUT_PAIRED) begin
          wr_en   = out_free;
        end
      end
      default:  busy_o = 1'b1;
    endcase
  end

  assign pop_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // slot table: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[cur_q.idx[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= pop_job_i;
    end
    if (finish) begin
      out_outcome_q <= outcome_d;
      out_sig_q     <= cur_q.sig;
      out_idx_q     <= cur_q.idx;
      out_partner_q <= partner_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.outcome         = out_outcome_q;
  assign out_o.signature       = out_sig_q;
  assign out_o.slot_index      = out_idx_q;
  assign out_o.partner_address = out_partner_q;

endmodule

// ===== src/signature_indexed_line_pair_table.sv =====
// signature indexed line pair table
//
// in_i carries one cache line transaction: line_address and eight sampled bytes.
// out_o returns exactly one result per transaction, in order: outcome, the
// ten-bit signature, the slot index used and the partner address (zero unless
// the outcome is a pairing with a different stored address).
//
// a front stage hashes the bytes and derives the slot index, a two-entry
// queue decouples it from the back end, which does a read-modify-write of the
// slot table through a single memory port.
// a result passes the front stage register, the queue, the back end's idle,
// read and decide states and the output register. the back end takes no new
// transaction until its pop, read and update steps for the last one are done.
//
// after reset the table is swept empty, one slot a cycle, until all TABLE_SLOTS
// slots are clear; in_i.ready stays low during the sweep.
// when the receiver stalls the result is held in the output register; the
// queue and front stage keep taking transactions until they fill.
module signature_indexed_line_pair_table import sitp_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sitp_in_if.sink    in_i,
  sitp_out_if.source out_o
);

  logic      push_valid;
  logic      push_ready;
  sitp_job_t push_job;
  logic      pop_valid;
  logic      pop_ready;
  sitp_job_t pop_job;
  logic      busy;

  sitp_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .busy_i       (busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  sitp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  sitp_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .busy_o      (busy),
    .out_o       (out_o)
  );

endmodule

// ===== src/sitp_checker.sv =====
module sitp_checker import sitp_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       out_outcome_i,
  input logic [SigW-1:0]  out_slot_index_i,
  input logic [AddrW-1:0] out_partner_i
);

  localparam logic [SigW:0] Slots = (SigW+1)'(TABLE_SLOTS);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i;
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("result dropped while stalled");

  property p_partner_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && (out_outcome_i != OUT_PAIRED) |-> (out_partner_i == '0);
  endproperty
  a_partner_zero: assert property (p_partner_zero)
    else $error("partner address set without a pairing");

  property p_slot_range;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> ({1'b0, out_slot_index_i} < Slots);
  endproperty
  a_slot_range: assert property (p_slot_range)
    else $error("slot index beyond table");

  property p_sweep_blocks;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(rst_ni) |-> !in_ready_i;
  endproperty
  a_sweep_blocks: assert property (p_sweep_blocks)
    else $error("transaction taken during table sweep");

endmodule

bind signature_indexed_line_pair_table sitp_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_sitp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_outcome_i    (out_o.outcome),
  .out_slot_index_i (out_o.slot_index),
  .out_partner_i    (out_o.partner_address)
);
